// ===== design/sparse_vector_kernel_top_macros.svh =====
// Assertion macros for the sparse vector kernel.
// Used by the top level; relies on clock and reset being in scope.
`ifndef SPARSE_VECTOR_KERNEL_TOP_MACROS_SVH
`define SPARSE_VECTOR_KERNEL_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SVK_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("svk assertion failed");

// Next-cycle implication, disabled during reset.
`define SVK_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("svk assertion failed");

`endif

// ===== design/svk_pkg.sv =====
// Package of the sparse vector kernel: types, codes and saturating helpers.
// Used by the interfaces, the multiplier unit and the top level.
package svk_pkg;

   localparam int IDX_W      = 16;
   localparam int VAL_W      = 32;
   localparam int RES_W      = 64;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] REG_MODE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_GAMMA  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_BIAS   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_DEGREE = 2'd3;

   // Kernel modes.
   localparam logic [1:0] MODE_LINEAR = 2'd0;
   localparam logic [1:0] MODE_RBF    = 2'd1;
   localparam logic [1:0] MODE_POLY   = 2'd2;
   localparam logic [1:0] MODE_TANH   = 2'd3;

   localparam logic [31:0] GAMMA_RESET  = 32'h0001_0000;
   localparam logic [3:0]  DEGREE_RESET = 4'd1;
   localparam logic [63:0] ONE_Q32      = 64'h0000_0001_0000_0000;
   localparam logic [63:0] INT64_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] INT64_MIN    = 64'h8000_0000_0000_0000;

   typedef enum logic [3:0] {
      ST_LOAD, ST_RD, ST_CMP, ST_MUL, ST_TWO, ST_SUB, ST_ADD,
      ST_LIN, ST_RBF, ST_TBIAS, ST_POWCHK, ST_POW, ST_OUT
   } seq_state_type;

   typedef enum logic [1:0] {PH_AB, PH_AA, PH_BB} phase_type;

   typedef enum logic [1:0] {MU_IDLE, MU_RUN, MU_FIN} mul_state_type;

   typedef enum logic [1:0] {SH_NONE, SH_Q16, SH_Q32} shift_type;

   typedef struct packed {
      logic        start;
      logic        narrow;
      shift_type   shift;
      logic        neg;
      logic [63:0] a_mag;
      logic [63:0] b_mag;
   } mul_req_type;

   typedef struct packed {
      logic        done;
      logic        busy;
      logic        sat;
      logic [63:0] value;
   } mul_rsp_type;

   typedef struct packed {
      logic        sat;
      logic [63:0] value;
   } sat_type;

   // Signed 64-bit add that clamps to the range.
   function automatic sat_type sat_add64(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      sat_type     r;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         r.sat   = 1'b1;
         r.value = s[64] ? INT64_MIN : INT64_MAX;
      end else begin
         r.sat   = 1'b0;
         r.value = s[63:0];
      end
      return r;
   endfunction

   // Signed 64-bit subtract that clamps to the range.
   function automatic sat_type sat_sub64(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      sat_type     r;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) begin
         r.sat   = 1'b1;
         r.value = s[64] ? INT64_MIN : INT64_MAX;
      end else begin
         r.sat   = 1'b0;
         r.value = s[63:0];
      end
      return r;
   endfunction

   function automatic logic [31:0] mag32(input logic [31:0] v);
      return v[31] ? (32'd0 - v) : v;
   endfunction

   function automatic logic [63:0] mag64(input logic [63:0] v);
      return v[63] ? (64'd0 - v) : v;
   endfunction

endpackage

// ===== design/svk_if.sv =====
// Channel interfaces of the sparse vector kernel: entry input and result output.
// Depends on svk_pkg for field widths.
interface svk_req_if;
   logic                         valid;
   logic                         ready;
   logic                         vector_select;
   logic [svk_pkg::IDX_W-1:0]    feature_index;
   logic signed [svk_pkg::VAL_W-1:0] feature_value;
   logic                         last_entry;

   modport source (output valid, vector_select, feature_index, feature_value, last_entry,
                   input ready);
   modport sink   (input valid, vector_select, feature_index, feature_value, last_entry,
                   output ready);
endinterface

interface svk_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [svk_pkg::RES_W-1:0] kernel_value;
   logic signed [svk_pkg::RES_W-1:0] dot_product;
   logic signed [svk_pkg::RES_W-1:0] squared_distance;
   logic                             overflow_flag;

   modport source (output valid, kernel_value, dot_product, squared_distance, overflow_flag,
                   input ready);
   modport sink   (input valid, kernel_value, dot_product, squared_distance, overflow_flag,
                   output ready);
endinterface

// ===== design/svk_mul.sv =====
// Shared multiplier unit: sign-magnitude 64 x 64 product built from 32 x 32 partial
// products over several cycles, then shifted, clamped and signed. Uses svk_pkg.
module svk_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  svk_pkg::mul_req_type req,
   output svk_pkg::mul_rsp_type rsp
);

   svk_pkg::mul_state_type state_ff, state_in;
   logic [2:0]         step_ff, step_in;
   logic [63:0]        a_ff, a_in;
   logic [63:0]        b_ff, b_in;
   logic               neg_ff, neg_in;
   logic               narrow_ff, narrow_in;
   svk_pkg::shift_type sh_ff, sh_in;
   logic [63:0]        pp_ff, pp_in;
   logic [127:0]       acc_ff, acc_in;
   logic               done_ff, done_in;
   logic               sat_ff, sat_in;
   logic [63:0]        res_ff, res_in;

   logic [31:0]  a_sel;
   logic [31:0]  b_sel;
   logic [63:0]  prod;
   logic [127:0] pp_ext;
   logic [127:0] shifted;
   logic [63:0]  lim;
   logic [2:0]   nsteps;

   // Operand halves for the current partial product.
   assign a_sel  = step_ff[1] ? a_ff[63:32] : a_ff[31:0];
   assign b_sel  = step_ff[0] ? b_ff[63:32] : b_ff[31:0];
   assign prod   = a_sel * b_sel;
   assign nsteps = narrow_ff ? 3'd1 : 3'd4;
   assign lim    = neg_ff ? svk_pkg::INT64_MIN : svk_pkg::INT64_MAX;

   // Weight of the partial product registered in the previous step.
   always_comb begin
      case (step_ff)
         3'd1:    pp_ext = {64'd0, pp_ff};
         3'd4:    pp_ext = {pp_ff, 64'd0};
         default: pp_ext = {32'd0, pp_ff, 32'd0};
      endcase
   end

   // Fixed-point alignment of the full product.
   always_comb begin
      case (sh_ff)
         svk_pkg::SH_Q16: shifted = acc_ff >> 16;
         svk_pkg::SH_Q32: shifted = acc_ff >> 32;
         default:         shifted = acc_ff;
      endcase
   end

   // Sequencer of the multiply steps.
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      neg_in    = neg_ff;
      narrow_in = narrow_ff;
      sh_in     = sh_ff;
      pp_in     = pp_ff;
      acc_in    = acc_ff;
      done_in   = 1'b0;
      sat_in    = sat_ff;
      res_in    = res_ff;
      case (state_ff)
         svk_pkg::MU_IDLE: begin
            if (req.start) begin
               a_in      = req.a_mag;
               b_in      = req.b_mag;
               neg_in    = req.neg;
               narrow_in = req.narrow;
               sh_in     = req.shift;
               acc_in    = '0;
               step_in   = '0;
               state_in  = svk_pkg::MU_RUN;
            end
         end
         svk_pkg::MU_RUN: begin
            if (step_ff < nsteps) begin
               pp_in = prod;
            end
            if (step_ff != 3'd0) begin
               acc_in = acc_ff + pp_ext;
            end
            if (step_ff == nsteps) begin
               state_in = svk_pkg::MU_FIN;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         svk_pkg::MU_FIN: begin
            if (shifted[127:64] != 64'd0 || shifted[63:0] > lim) begin
               sat_in = 1'b1;
               res_in = neg_ff ? svk_pkg::INT64_MIN : svk_pkg::INT64_MAX;
            end else begin
               sat_in = 1'b0;
               res_in = neg_ff ? (64'd0 - shifted[63:0]) : shifted[63:0];
            end
            done_in  = 1'b1;
            state_in = svk_pkg::MU_IDLE;
         end
         default: state_in = svk_pkg::MU_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= svk_pkg::MU_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      step_ff   <= step_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      neg_ff    <= neg_in;
      narrow_ff <= narrow_in;
      sh_ff     <= sh_in;
      pp_ff     <= pp_in;
      acc_ff    <= acc_in;
      sat_ff    <= sat_in;
      res_ff    <= res_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.busy  = (state_ff != svk_pkg::MU_IDLE);
   assign rsp.sat   = sat_ff;
   assign rsp.value = res_ff;

endmodule

// ===== design/sparse_vector_kernel_top.sv =====
// Sparse vector kernel unit. Entries of vector A, then vector B, come in on req_if; one
// result per B vector goes out on rsp_if. Configuration is written through the csr_ port.
//
// Loading: req_if.ready is high while the block collects entries, one entry item per cycle.
// Each vector keeps up to MAX_ENTRIES entries; further entries are dropped and flagged.
// The item with vector_select = 1 and last_entry = 1 starts the computation, and ready
// stays low until the result has been placed in the output register.
// After that item the sequencer runs these steps on the single shared multiplier:
//   merge walk A.B, with a product only at each matching index;
//   A.A and B.B, with a product per stored entry, each walk then closed;
//   distance, gamma*dot, kernel stage: one product (rbf) or one product per
//   degree step (polynomial), then the load into the output register.
// The output register holds a result until rsp_if.ready; a stalled receiver lets the
// next pair load, but the next computation waits at its end for the register to free.
// Reset (synchronous, active high) empties both vectors, clears the flags and returns
// the registers to linear mode, gamma 1.0, bias 0, degree 1. The entry stores need no
// clearing pass: only entries written since the last result are read.
`include "sparse_vector_kernel_top_macros.svh"

module sparse_vector_kernel_top #(
   parameter int MAX_ENTRIES = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   svk_req_if.sink                         req_if,
   svk_rsp_if.source                       rsp_if,
   input  logic                            csr_we,
   input  logic [svk_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [svk_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int EW = svk_pkg::IDX_W + svk_pkg::VAL_W;
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ENTRIES);

   // Configuration registers.
   logic [1:0]  mode_ff;
   logic [31:0] gamma_ff;
   logic [31:0] bias_ff;
   logic [3:0]  degree_ff;

   // Sequencer state.
   svk_pkg::seq_state_type state_ff, state_in;
   svk_pkg::phase_type     phase_ff, phase_in;
   logic [CW-1:0] cnt_a_ff, cnt_a_in;
   logic [CW-1:0] cnt_b_ff, cnt_b_in;
   logic          dropped_ff, dropped_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] j_ff, j_in;
   logic [63:0]   acc_ff, acc_in;
   logic [63:0]   ab_ff, ab_in;
   logic [63:0]   aa_ff, aa_in;
   logic [63:0]   bb_ff, bb_in;
   logic [63:0]   dist_ff, dist_in;
   logic [63:0]   lin_ff, lin_in;
   logic [63:0]   t_ff, t_in;
   logic [63:0]   kv_ff, kv_in;
   logic [3:0]    pow_ff, pow_in;
   logic          sat_ff, sat_in;

   // Output register.
   logic          rsp_valid_ff, rsp_valid_in;
   logic [63:0]   rsp_kv_ff;
   logic [63:0]   rsp_dot_ff;
   logic [63:0]   rsp_dist_ff;
   logic          rsp_ovf_ff;
   logic          rsp_load;

   // Entry stores.
   logic [EW-1:0] mem_a [MAX_ENTRIES];
   logic [EW-1:0] mem_b [MAX_ENTRIES];
   logic [EW-1:0] rd_a_ff;
   logic [EW-1:0] rd_b_ff;
   logic          wr_a;
   logic          wr_b;

   svk_pkg::mul_req_type mul_req;
   svk_pkg::mul_rsp_type mul_rsp;
   svk_pkg::sat_type     sum_v;

   logic [15:0] a_idx;
   logic [15:0] b_idx;
   logic [31:0] x_val;
   logic [31:0] y_val;
   logic [63:0] bias_q32;
   logic [63:0] gamma_ext;
   logic        gamma_pos;
   logic        walk_end;

   assign a_idx     = rd_a_ff[EW-1:svk_pkg::VAL_W];
   assign b_idx     = rd_b_ff[EW-1:svk_pkg::VAL_W];
   assign bias_q32  = {{16{bias_ff[31]}}, bias_ff, 16'd0};
   assign gamma_ext = {{32{gamma_ff[31]}}, gamma_ff};
   assign gamma_pos = !gamma_ff[31] && (gamma_ff != 32'd0);

   // Operands of the current walk: A against B, or a vector against itself.
   always_comb begin
      case (phase_ff)
         svk_pkg::PH_AB: begin
            x_val    = rd_a_ff[31:0];
            y_val    = rd_b_ff[31:0];
            walk_end = (i_ff >= cnt_a_ff) || (j_ff >= cnt_b_ff);
         end
         svk_pkg::PH_AA: begin
            x_val    = rd_a_ff[31:0];
            y_val    = rd_a_ff[31:0];
            walk_end = (i_ff >= cnt_a_ff);
         end
         default: begin
            x_val    = rd_b_ff[31:0];
            y_val    = rd_b_ff[31:0];
            walk_end = (j_ff >= cnt_b_ff);
         end
      endcase
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= svk_pkg::MODE_LINEAR;
         gamma_ff  <= svk_pkg::GAMMA_RESET;
         bias_ff   <= 32'd0;
         degree_ff <= svk_pkg::DEGREE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            svk_pkg::REG_MODE:   mode_ff   <= csr_wdata[1:0];
            svk_pkg::REG_GAMMA:  gamma_ff  <= csr_wdata;
            svk_pkg::REG_BIAS:   bias_ff   <= csr_wdata;
            svk_pkg::REG_DEGREE: degree_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // Sequencer: loading, merge walks, distance and kernel stages.
   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      cnt_a_in   = cnt_a_ff;
      cnt_b_in   = cnt_b_ff;
      dropped_in = dropped_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      acc_in     = acc_ff;
      ab_in      = ab_ff;
      aa_in      = aa_ff;
      bb_in      = bb_ff;
      dist_in    = dist_ff;
      lin_in     = lin_ff;
      t_in       = t_ff;
      kv_in      = kv_ff;
      pow_in     = pow_ff;
      sat_in     = sat_ff;
      wr_a       = 1'b0;
      wr_b       = 1'b0;
      rsp_load   = 1'b0;
      sum_v      = '0;
      mul_req    = '0;
      case (state_ff)
         svk_pkg::ST_LOAD: begin
            if (req_if.valid) begin
               if (!req_if.vector_select) begin
                  if (cnt_a_ff < CNT_MAX) begin
                     wr_a     = 1'b1;
                     cnt_a_in = cnt_a_ff + 1'b1;
                  end else begin
                     dropped_in = 1'b1;
                  end
               end else begin
                  if (cnt_b_ff < CNT_MAX) begin
                     wr_b     = 1'b1;
                     cnt_b_in = cnt_b_ff + 1'b1;
                  end else begin
                     dropped_in = 1'b1;
                  end
                  if (req_if.last_entry) begin
                     state_in = svk_pkg::ST_RD;
                     phase_in = svk_pkg::PH_AB;
                     i_in     = '0;
                     j_in     = '0;
                     acc_in   = '0;
                     sat_in   = 1'b0;
                  end
               end
            end
         end
         svk_pkg::ST_RD: begin
            if (walk_end) begin
               acc_in = '0;
               i_in   = '0;
               j_in   = '0;
               case (phase_ff)
                  svk_pkg::PH_AB: begin
                     ab_in    = acc_ff;
                     phase_in = svk_pkg::PH_AA;
                  end
                  svk_pkg::PH_AA: begin
                     aa_in    = acc_ff;
                     phase_in = svk_pkg::PH_BB;
                  end
                  default: begin
                     bb_in    = acc_ff;
                     state_in = svk_pkg::ST_TWO;
                  end
               endcase
            end else begin
               state_in = svk_pkg::ST_CMP;
            end
         end
         svk_pkg::ST_CMP: begin
            if (phase_ff != svk_pkg::PH_AB || a_idx == b_idx) begin
               mul_req.start  = 1'b1;
               mul_req.narrow = 1'b1;
               mul_req.shift  = svk_pkg::SH_NONE;
               mul_req.neg    = x_val[31] ^ y_val[31];
               mul_req.a_mag  = {32'd0, svk_pkg::mag32(x_val)};
               mul_req.b_mag  = {32'd0, svk_pkg::mag32(y_val)};
               state_in       = svk_pkg::ST_MUL;
            end else if (a_idx > b_idx) begin
               j_in     = j_ff + 1'b1;
               state_in = svk_pkg::ST_RD;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = svk_pkg::ST_RD;
            end
         end
         svk_pkg::ST_MUL: begin
            if (mul_rsp.done) begin
               sum_v  = svk_pkg::sat_add64(acc_ff, mul_rsp.value);
               acc_in = sum_v.value;
               sat_in = sat_ff | sum_v.sat;
               if (phase_ff != svk_pkg::PH_BB) begin
                  i_in = i_ff + 1'b1;
               end
               if (phase_ff != svk_pkg::PH_AA) begin
                  j_in = j_ff + 1'b1;
               end
               state_in = svk_pkg::ST_RD;
            end
         end
         svk_pkg::ST_TWO: begin
            sum_v    = svk_pkg::sat_add64(ab_ff, ab_ff);
            dist_in  = sum_v.value;
            sat_in   = sat_ff | sum_v.sat;
            state_in = svk_pkg::ST_SUB;
         end
         svk_pkg::ST_SUB: begin
            sum_v    = svk_pkg::sat_sub64(aa_ff, dist_ff);
            dist_in  = sum_v.value;
            sat_in   = sat_ff | sum_v.sat;
            state_in = svk_pkg::ST_ADD;
         end
         svk_pkg::ST_ADD: begin
            sum_v          = svk_pkg::sat_add64(dist_ff, bb_ff);
            dist_in        = sum_v.value;
            sat_in         = sat_ff | sum_v.sat;
            mul_req.start  = 1'b1;
            mul_req.shift  = svk_pkg::SH_Q16;
            mul_req.neg    = gamma_ff[31] ^ ab_ff[63];
            mul_req.a_mag  = svk_pkg::mag64(gamma_ext);
            mul_req.b_mag  = svk_pkg::mag64(ab_ff);
            state_in       = svk_pkg::ST_LIN;
         end
         svk_pkg::ST_LIN: begin
            if (mul_rsp.done) begin
               lin_in = mul_rsp.value;
               sat_in = sat_ff | mul_rsp.sat;
               case (mode_ff)
                  svk_pkg::MODE_LINEAR: begin
                     kv_in    = mul_rsp.value;
                     state_in = svk_pkg::ST_OUT;
                  end
                  svk_pkg::MODE_RBF: begin
                     mul_req.start = 1'b1;
                     mul_req.shift = svk_pkg::SH_Q16;
                     mul_req.neg   = gamma_pos ^ dist_ff[63];
                     mul_req.a_mag = svk_pkg::mag64(gamma_ext);
                     mul_req.b_mag = svk_pkg::mag64(dist_ff);
                     state_in      = svk_pkg::ST_RBF;
                  end
                  svk_pkg::MODE_POLY: begin
                     state_in = svk_pkg::ST_TBIAS;
                  end
                  default: begin
                     sum_v    = svk_pkg::sat_add64(mul_rsp.value, bias_q32);
                     kv_in    = sum_v.value;
                     sat_in   = sat_ff | mul_rsp.sat | sum_v.sat;
                     state_in = svk_pkg::ST_OUT;
                  end
               endcase
            end
         end
         svk_pkg::ST_RBF: begin
            if (mul_rsp.done) begin
               kv_in    = mul_rsp.value;
               sat_in   = sat_ff | mul_rsp.sat;
               state_in = svk_pkg::ST_OUT;
            end
         end
         svk_pkg::ST_TBIAS: begin
            sum_v    = svk_pkg::sat_add64(lin_ff, bias_q32);
            t_in     = sum_v.value;
            sat_in   = sat_ff | sum_v.sat;
            kv_in    = svk_pkg::ONE_Q32;
            pow_in   = degree_ff;
            state_in = svk_pkg::ST_POWCHK;
         end
         svk_pkg::ST_POWCHK: begin
            if (pow_ff == 4'd0) begin
               state_in = svk_pkg::ST_OUT;
            end else begin
               mul_req.start = 1'b1;
               mul_req.shift = svk_pkg::SH_Q32;
               mul_req.neg   = kv_ff[63] ^ t_ff[63];
               mul_req.a_mag = svk_pkg::mag64(kv_ff);
               mul_req.b_mag = svk_pkg::mag64(t_ff);
               state_in      = svk_pkg::ST_POW;
            end
         end
         svk_pkg::ST_POW: begin
            if (mul_rsp.done) begin
               kv_in    = mul_rsp.value;
               sat_in   = sat_ff | mul_rsp.sat;
               pow_in   = pow_ff - 4'd1;
               state_in = svk_pkg::ST_POWCHK;
            end
         end
         svk_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_load   = 1'b1;
               cnt_a_in   = '0;
               cnt_b_in   = '0;
               dropped_in = 1'b0;
               state_in   = svk_pkg::ST_LOAD;
            end
         end
         default: state_in = svk_pkg::ST_LOAD;
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= svk_pkg::ST_LOAD;
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_a_ff     <= cnt_a_in;
         cnt_b_ff     <= cnt_b_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      phase_ff <= phase_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      acc_ff   <= acc_in;
      ab_ff    <= ab_in;
      aa_ff    <= aa_in;
      bb_ff    <= bb_in;
      dist_ff  <= dist_in;
      lin_ff   <= lin_in;
      t_ff     <= t_in;
      kv_ff    <= kv_in;
      pow_ff   <= pow_in;
      sat_ff   <= sat_in;
      if (rsp_load) begin
         rsp_kv_ff   <= kv_ff;
         rsp_dot_ff  <= ab_ff;
         rsp_dist_ff <= dist_ff;
         rsp_ovf_ff  <= dropped_ff | sat_ff;
      end
   end

   // Entry stores: one write port each, registered read at the walk pointers.
   always_ff @(posedge clock) begin
      if (wr_a) begin
         mem_a[cnt_a_ff[AW-1:0]] <= {req_if.feature_index, req_if.feature_value};
      end
      rd_a_ff <= mem_a[i_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (wr_b) begin
         mem_b[cnt_b_ff[AW-1:0]] <= {req_if.feature_index, req_if.feature_value};
      end
      rd_b_ff <= mem_b[j_ff[AW-1:0]];
   end

   svk_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   assign req_if.ready            = (state_ff == svk_pkg::ST_LOAD);
   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.kernel_value     = rsp_kv_ff;
   assign rsp_if.dot_product      = rsp_dot_ff;
   assign rsp_if.squared_distance = rsp_dist_ff;
   assign rsp_if.overflow_flag    = rsp_ovf_ff;

   // Counts never pass the store depth.
   `SVK_ASSERT_IMPL(a_cnt_bound, 1'b1, (cnt_a_ff <= CNT_MAX) && (cnt_b_ff <= CNT_MAX))
   // The shared unit is only started when idle.
   `SVK_ASSERT_IMPL(a_mul_idle, mul_req.start, !mul_rsp.busy)
   // A finished product is only delivered to a state that waits for it.
   `SVK_ASSERT_IMPL(a_mul_done, mul_rsp.done,
      (state_ff == svk_pkg::ST_MUL) || (state_ff == svk_pkg::ST_LIN) ||
      (state_ff == svk_pkg::ST_RBF) || (state_ff == svk_pkg::ST_POW))
   // Loading a result empties both vectors for the next pair.
   `SVK_ASSERT_NEXT(a_clear, rsp_load,
      rsp_if.valid && (cnt_a_ff == '0) && (cnt_b_ff == '0) && !dropped_ff)

endmodule
